/* rtl/core/scfr_pkg.sv */
// ----------------------------------------------------------------------------
// scfr_pkg
// Types, codes and CRC helper for the speed command frame relay.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int FRAME_LEN = 8;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(2 * FRAME_LEN);

    localparam logic [7:0]  START_BYTE    = 8'hAA;
    localparam logic [7:0]  FUNC_WRITE    = 8'h06;
    localparam logic [7:0]  REG_HI_EXPECT = 8'h01;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    localparam logic [14:0] SPEED_LIMIT_RST    = 15'd1500;
    localparam logic [7:0]  ACCEPT_ADDR_RST    = 8'd1;
    localparam logic [7:0]  MOTOR_ADDR_RST     = 8'd1;
    localparam logic [15:0] SPEED_REGISTER_RST = 16'd2;

    typedef enum logic [1:0] {
        CFG_SPEED_LIMIT    = 2'd0,
        CFG_ACCEPT_ADDRESS = 2'd1,
        CFG_MOTOR_ADDRESS  = 2'd2,
        CFG_SPEED_REGISTER = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic       dest_port;
        logic [7:0] tx_byte;
        logic       run_last;
    } out_item_t;

    // one byte of the reflected modbus crc, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* rtl/core/speed_command_frame_relay.sv */
// ----------------------------------------------------------------------------
// speed_command_frame_relay
// Checks received command frames and relays a clamped speed to the motor.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle. A frame that passes its checks
// (start byte, address, function, register, CRC) is answered with sixteen
// output transactions: the eight-byte motor write frame, then an echo of the
// eight received bytes, at most one per cycle. Bytes without the end mark are
// always taken in the cycle they arrive, also while a reply is still
// draining; an end-marked byte waits while a previous reply is being sent.
// The motor frame CRC is built one byte per output transaction as the
// frame goes out.
module speed_command_frame_relay
    import scfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [14:0] speed_limit_reg;
    logic [7:0]  accept_address_reg;
    logic [7:0]  motor_address_reg;
    logic [15:0] speed_register_reg;

    logic [CNT_W-1:0] byte_count_reg;
    logic [7:0]       frame_store_reg [FRAME_LEN];
    logic [15:0]      running_check_reg;

    logic             out_busy_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [7:0]       echo_reg [FRAME_LEN];
    logic [15:0]      speed_reg;
    logic [15:0]      tx_crc_reg;

    logic        in_fire, out_fire, store_open, frame_ok;
    logic [7:0]  store_eff [FRAME_LEN];
    logic [15:0] check_eff, speed_raw, speed_clamped, lim_pos, lim_neg;
    logic [7:0]  tx_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = !(in_data.end_of_frame && out_busy_reg);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_busy_reg;
    assign out_fire  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg    <= SPEED_LIMIT_RST;
            accept_address_reg <= ACCEPT_ADDR_RST;
            motor_address_reg  <= MOTOR_ADDR_RST;
            speed_register_reg <= SPEED_REGISTER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data[14:0];
                CFG_ACCEPT_ADDRESS: accept_address_reg <= cfg_data[7:0];
                CFG_MOTOR_ADDRESS:  motor_address_reg  <= cfg_data[7:0];
                CFG_SPEED_REGISTER: speed_register_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // store and check as they stand once the current byte is in
    assign store_open = (byte_count_reg < CNT_W'(FRAME_LEN));

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (store_open && (byte_count_reg == CNT_W'(i)))
                store_eff[i] = in_data.rx_byte;
            else
                store_eff[i] = frame_store_reg[i];
        end
        if (store_open && (byte_count_reg >= CNT_W'(1)) && (byte_count_reg <= CNT_W'(5)))
            check_eff = crc_byte(running_check_reg, in_data.rx_byte);
        else
            check_eff = running_check_reg;
    end

    assign frame_ok = (byte_count_reg >= CNT_W'(FRAME_LEN - 1))
                   && (store_eff[0] == START_BYTE)
                   && (check_eff == {store_eff[7], store_eff[6]})
                   && (store_eff[1] == accept_address_reg)
                   && (store_eff[2] == FUNC_WRITE)
                   && (store_eff[3] == REG_HI_EXPECT);

    assign speed_raw = {store_eff[4], store_eff[5]};
    assign lim_pos   = {1'b0, speed_limit_reg};
    assign lim_neg   = 16'(-$signed(lim_pos));

    always_comb
    begin
        if ($signed(speed_raw) > $signed(lim_pos))
            speed_clamped = lim_pos;
        else if ($signed(speed_raw) < $signed(lim_neg))
            speed_clamped = lim_neg;
        else
            speed_clamped = speed_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            running_check_reg <= CRC_INIT;
        end
        else if (in_fire)
        begin
            if (in_data.end_of_frame)
            begin
                byte_count_reg    <= '0;
                running_check_reg <= CRC_INIT;
            end
            else
            begin
                running_check_reg <= check_eff;
                if (store_open)
                    byte_count_reg <= byte_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
                frame_store_reg[i] <= store_eff[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
        end
        else if (in_fire && in_data.end_of_frame && frame_ok)
        begin
            out_busy_reg <= 1'b1;
            out_idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            if (out_idx_reg == IDX_W'(2 * FRAME_LEN - 1))
                out_busy_reg <= 1'b0;
            out_idx_reg <= out_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.end_of_frame && frame_ok)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
                echo_reg[i] <= store_eff[i];
            speed_reg  <= speed_clamped;
            tx_crc_reg <= CRC_INIT;
        end
        else if (out_fire && (out_idx_reg < IDX_W'(6)))
        begin
            tx_crc_reg <= crc_byte(tx_crc_reg, tx_byte);
        end
    end

    always_comb
    begin
        case (out_idx_reg[2:0])
            3'd0:    tx_byte = motor_address_reg;
            3'd1:    tx_byte = FUNC_WRITE;
            3'd2:    tx_byte = speed_register_reg[15:8];
            3'd3:    tx_byte = speed_register_reg[7:0];
            3'd4:    tx_byte = speed_reg[15:8];
            3'd5:    tx_byte = speed_reg[7:0];
            3'd6:    tx_byte = tx_crc_reg[7:0];
            default: tx_byte = tx_crc_reg[15:8];
        endcase
        out_data.dest_port = out_idx_reg[IDX_W-1];
        out_data.tx_byte   = out_idx_reg[IDX_W-1] ? echo_reg[out_idx_reg[2:0]] : tx_byte;
        out_data.run_last  = (out_idx_reg[2:0] == 3'd7);
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(FRAME_LEN))
        else $error("byte count beyond frame length");

    a_reply_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_busy_reg) |-> (out_idx_reg == '0))
        else $error("reply did not start at first byte");

    a_reply_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && (out_idx_reg == IDX_W'(2 * FRAME_LEN - 1))) |=> !out_busy_reg)
        else $error("reply kept running after last byte");

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.end_of_frame) |=>
            ((byte_count_reg == '0) && (running_check_reg == CRC_INIT)))
        else $error("frame state not cleared after end mark");

endmodule

/* bench/tb_speed_command_frame_relay.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speed_command_frame_relay
// Drives command frames into the relay and checks every transmitted byte.
// ----------------------------------------------------------------------------
// Frames are built with a correct CRC and then, for a share of them, broken
// in one field, cut short, lengthened or replaced by noise. A local copy of
// the frame checker and motor frame builder predicts the sixteen output
// transactions of each accepted frame; a monitor compares them in order.
// Both handshakes stall in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module tb_speed_command_frame_relay;
    import scfr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BYTES   = 56;

    typedef enum int {
        GOOD,
        BAD_START,
        BAD_ADDR,
        BAD_FUNC,
        BAD_REG,
        BAD_CRC,
        SHORT,
        NOISE
    } frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;

    // local copy of the block's registers and frame state
    logic [14:0] limit_q;
    logic [7:0]  accept_q;
    logic [7:0]  motor_q;
    logic [15:0] register_q;
    logic [3:0]  rx_count;
    logic [7:0]  rx_store [FRAME_LEN];
    logic [15:0] rx_crc;

    out_item_t   pending_tx [$];
    int          fault_count = 0;
    int          cycle_count = 0;
    int          rx_taken    = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;

    speed_command_frame_relay i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [15:0] modbus_crc_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void push_tx(logic port, logic [7:0] b, logic last);
        out_item_t e;
        e.dest_port = port;
        e.tx_byte   = b;
        e.run_last  = last;
        pending_tx.push_back(e);
    endfunction

    // one received byte: store, crc, and on the end mark the whole reply
    function automatic void predict_relay(in_item_t it);
        logic               ok;
        logic signed [15:0] req;
        int                 spd;
        int                 lim;
        logic [15:0]        sp;
        logic [15:0]        crc;
        logic [7:0]         motor [FRAME_LEN];
        if (rx_count < FRAME_LEN)
        begin
            rx_store[rx_count[2:0]] = it.rx_byte;
            if (rx_count >= 1 && rx_count <= 5)
                rx_crc = modbus_crc_step(rx_crc, it.rx_byte);
            rx_count = rx_count + 4'd1;
        end
        if (it.end_of_frame)
        begin
            ok = (rx_count >= FRAME_LEN) && (rx_store[0] == START_BYTE)
                && (rx_crc == {rx_store[7], rx_store[6]})
                && (rx_store[1] == accept_q) && (rx_store[2] == FUNC_WRITE)
                && (rx_store[3] == REG_HI_EXPECT);
            rx_count = '0;
            rx_crc   = CRC_INIT;
            if (ok)
            begin
                req = {rx_store[4], rx_store[5]};
                spd = req;
                lim = int'(limit_q);
                if (spd > lim)
                    spd = lim;
                if (spd < -lim)
                    spd = -lim;
                sp = spd[15:0];
                motor[0] = motor_q;
                motor[1] = FUNC_WRITE;
                motor[2] = register_q[15:8];
                motor[3] = register_q[7:0];
                motor[4] = sp[15:8];
                motor[5] = sp[7:0];
                crc = CRC_INIT;
                for (int i = 0; i < 6; i++)
                    crc = modbus_crc_step(crc, motor[i]);
                motor[6] = crc[7:0];
                motor[7] = crc[15:8];
                for (int i = 0; i < FRAME_LEN; i++)
                    push_tx(1'b0, motor[i], i == FRAME_LEN - 1);
                for (int i = 0; i < FRAME_LEN; i++)
                    push_tx(1'b1, rx_store[i], i == FRAME_LEN - 1);
            end
        end
    endfunction

    function automatic logic [15:0] pick_speed();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 65535);
            1: v = int'(limit_q) + $urandom_range(0, 4) - 2;
            2: v = -int'(limit_q) + $urandom_range(0, 4) - 2;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    // one input transaction, then perhaps an idle burst
    task automatic send_rx(logic [7:0] b, logic eof);
        in_item_t it;
        it.rx_byte      = b;
        it.end_of_frame = eof;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_relay(it);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_command(frame_kind_t kind, logic [15:0] speed, int extra);
        logic [7:0]  f [FRAME_LEN];
        logic [15:0] c;
        int          n;
        int          k;
        f[0] = START_BYTE;
        f[1] = accept_q;
        f[2] = FUNC_WRITE;
        f[3] = REG_HI_EXPECT;
        f[4] = speed[15:8];
        f[5] = speed[7:0];
        c = CRC_INIT;
        for (int i = 1; i < 6; i++)
            c = modbus_crc_step(c, f[i]);
        f[6] = c[7:0];
        f[7] = c[15:8];
        n = FRAME_LEN + extra;
        case (kind)
            BAD_START: f[0] = f[0] ^ 8'($urandom_range(1, 255));
            BAD_ADDR:  f[1] = f[1] ^ 8'($urandom_range(1, 255));
            BAD_FUNC:  f[2] = f[2] ^ 8'($urandom_range(1, 255));
            BAD_REG:   f[3] = f[3] ^ 8'($urandom_range(1, 255));
            BAD_CRC:
            begin
                k = $urandom_range(4, 7);
                f[k] = f[k] ^ 8'($urandom_range(1, 255));
            end
            SHORT: n = $urandom_range(1, FRAME_LEN - 1);
            NOISE:
            begin
                for (int i = 0; i < FRAME_LEN; i++)
                    f[i] = 8'($urandom);
                n = $urandom_range(1, 12);
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i < FRAME_LEN)
                rx_taken++;
            send_rx(i < FRAME_LEN ? f[i] : 8'($urandom), i == n - 1);
        end
    endtask

    // stop sending and let the block finish whatever it holds
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_tx.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SPEED_LIMIT:    limit_q    = val[14:0];
            CFG_ACCEPT_ADDRESS: accept_q   = val[7:0];
            CFG_MOTOR_ADDRESS:  motor_q    = val[7:0];
            CFG_SPEED_REGISTER: register_q = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] lim, logic [7:0] acc, logic [7:0] mot,
                              logic [15:0] rnum);
        write_reg(CFG_SPEED_LIMIT, lim);
        write_reg(CFG_ACCEPT_ADDRESS, {8'($urandom), acc});
        write_reg(CFG_MOTOR_ADDRESS, {8'($urandom), mot});
        write_reg(CFG_SPEED_REGISTER, rnum);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // full positive speed against the reset limit
        send_command(GOOD, 16'h7FFF, 0);
    endtask

    task automatic test_short_frame();
        send_command(SHORT, 16'h0000, 0);
    endtask

    task automatic test_long_frame();
        send_command(GOOD, 16'h8000, 1);
    endtask

    task automatic test_full_scale_limit();
        wait_drained();
        // bit 15 set on purpose, the limit is only fifteen bits wide
        set_config(16'hFFFF, ACCEPT_ADDR_RST, MOTOR_ADDR_RST, SPEED_REGISTER_RST);
        send_command(GOOD, 16'h8000, 0);
    endtask

    task automatic run_random_phase();
        int          target;
        frame_kind_t kind;
        target = rx_taken + PHASE_BYTES;
        while (rx_taken < target)
        begin
            if ($urandom_range(0, 9) < 7)
                send_command(GOOD, pick_speed(),
                             ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            else
            begin
                kind = frame_kind_t'($urandom_range(1, 7));
                send_command(kind, pick_speed(), 0);
            end
        end
    endtask

    task automatic test_random_traffic();
        wait_drained();
        set_config(16'h0000, 8'h00, 8'hFF, 16'hFFFF);
        run_random_phase();
        wait_drained();
        set_config(16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        run_random_phase();
        wait_drained();
        set_config(16'h7FFF, 8'hFF, 8'h00, 16'h0000);
        run_random_phase();
        wait_drained();
        set_config(16'($urandom_range(0, 4000)), 8'($urandom), 8'($urandom),
                   16'($urandom));
        calm = 1'b1;
        run_random_phase();
    endtask

    // receiver side: random stall bursts, always ready once calm is set
    always @(posedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tx.size() == 0)
            begin
                $display("%0t: unexpected tx transaction, ",
                         "actual port %0d byte %02h last %0d",
                         $time, out_data.dest_port, out_data.tx_byte, out_data.run_last);
                fault_count++;
            end
            else
            begin
                want = pending_tx.pop_front();
                if (out_data.dest_port !== want.dest_port || out_data.tx_byte !== want.tx_byte
                    || out_data.run_last !== want.run_last)
                begin
                    $display("%0t: tx mismatch, expected port %0d byte %02h last %0d, ",
                             $time, want.dest_port, want.tx_byte, want.run_last,
                             "actual port %0d byte %02h last %0d",
                             out_data.dest_port, out_data.tx_byte, out_data.run_last);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SPEED_LIMIT;
        cfg_data  <= '0;
        limit_q    = SPEED_LIMIT_RST;
        accept_q   = ACCEPT_ADDR_RST;
        motor_q    = MOTOR_ADDR_RST;
        register_q = SPEED_REGISTER_RST;
        rx_count   = '0;
        rx_crc     = CRC_INIT;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_short_frame();
        test_long_frame();
        test_full_scale_limit();
        test_random_traffic();

        wait_drained();
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
